FILE: sv/pedi_pkg.sv
// Shared constants and types for the polynomial evaluator.
// Used by the divider unit and the top level; depends on nothing.
package pedi_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_DEGREE_DEF = 10;
	localparam int FRAC_BITS_DEF = 16;

	// Operation codes.
	localparam logic [2:0] OP_LOAD = 3'd0;
	localparam logic [2:0] OP_EVAL = 3'd1;
	localparam logic [2:0] OP_DERIV = 3'd2;
	localparam logic [2:0] OP_INTEG = 3'd3;
	localparam logic [2:0] OP_SLOPE = 3'd4;

	// Status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_INTERVAL = 2'd2;
	localparam logic [1:0] ST_INDEX = 2'd3;

	// Saturation limits of a 32-bit result.
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// Divider request and status.
	typedef struct packed {
		logic start;
		logic short_mode;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

FILE: sv/pedi_if.sv
// Handshake interfaces for the request and result channels.
// Self-contained; widths follow the fixed item fields.
interface pedi_req_if;
	logic valid;
	logic ready;
	logic [2:0] operation;
	logic [3:0] coef_index;
	logic signed [31:0] coef_value;
	logic signed [31:0] x_a;
	logic signed [31:0] x_b;

	modport source(output valid, operation, coef_index, coef_value, x_a, x_b, input ready);
	modport sink(input valid, operation, coef_index, coef_value, x_a, x_b, output ready);
endinterface

interface pedi_rsp_if;
	logic valid;
	logic ready;
	logic signed [31:0] result_value;
	logic [1:0] status;

	modport source(output valid, result_value, status, input ready);
	modport sink(input valid, result_value, status, output ready);
endinterface

FILE: sv/polynomial_eval_derivative_integral.sv
// Polynomial evaluator with derivative, integral and secant slope by Horner's rule.
// One item at a time: the shared multiplier and the bit-serial divider set the rate, and a
// new request is taken only after the last result is taken. Reset clears the table and the
// degree at once.
// Depends on pedi_pkg, pedi_if and pedi_div.
module polynomial_eval_derivative_integral #(
	parameter int MAX_DEGREE = pedi_pkg::MAX_DEGREE_DEF,
	parameter int FRAC_BITS = pedi_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [3:0] cfg_wdata,
	pedi_req_if.sink req,
	pedi_rsp_if.source rsp
);
	import pedi_pkg::*;

	localparam int IDX_W = $clog2(MAX_DEGREE + 1);
	localparam int TW = 38;
	localparam int MSH_W = 64 - FRAC_BITS;
	localparam int SUM_W = MSH_W + 1;
	localparam int DVW = 33 + FRAC_BITS;

	// Sequencer states.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_START = 4'd1;
	localparam logic [3:0] S_TERM = 4'd2;
	localparam logic [3:0] S_TWAIT = 4'd3;
	localparam logic [3:0] S_TDIV = 4'd4;
	localparam logic [3:0] S_ACC = 4'd5;
	localparam logic [3:0] S_MUL = 4'd6;
	localparam logic [3:0] S_MSH = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;
	localparam logic [3:0] S_SDIV = 4'd9;
	localparam logic [3:0] S_OUT = 4'd10;

	logic [3:0] state_q;
	logic [3:0] deg_q;
	logic signed [31:0] coef_q [MAX_DEGREE+1];
	logic [2:0] op_q;
	logic [IDX_W-1:0] j_q, d_q, d_used, jmin;
	logic first_q, fin_q, chain_q, sat_q;
	logic [1:0] err_q;
	logic signed [31:0] a_q, b_q, x_q, acc_q, up_q, pa_q, res_q;
	logic signed [TW-1:0] t_q;
	logic signed [MSH_W-1:0] msh_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] mul_a, mul_b;
	logic signed [SUM_W-1:0] sum;
	logic [SUM_W-32:0] sum_hi;
	logic sum_ovf;
	logic signed [31:0] sum_sat;
	logic signed [32:0] diff;
	logic diff_ovf;
	logic signed [31:0] diff_sat;
	logic signed [32:0] dy;
	logic [DVW-32:0] q_hi;
	logic q_ovf;
	logic signed [31:0] q_sat;
	div_ctl_t div_ctl;
	div_sts_t div_sts;
	logic signed [DVW-1:0] div_dividend, div_quot;
	logic [31:0] div_divisor;

	// Degree in use, clamped to the table size.
	assign d_used = (int'(deg_q) > MAX_DEGREE) ? IDX_W'(MAX_DEGREE) : IDX_W'(deg_q);
	assign jmin = (op_q == OP_DERIV) ? IDX_W'(1) : IDX_W'(0);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= '0;
		end else if (cfg_we) begin
			deg_q <= cfg_wdata;
		end
	end

	// Shared multiplier with a registered product.
	always_comb begin
		if (state_q == S_TERM) begin
			mul_a = coef_q[j_q];
			mul_b = $signed(32'(j_q));
		end else begin
			mul_a = acc_q;
			mul_b = x_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	// Horner step sum and its saturation.
	assign sum = (first_q ? SUM_W'(0) : SUM_W'(msh_q)) + SUM_W'(t_q);
	assign sum_hi = sum[SUM_W-1:31];
	assign sum_ovf = !((&sum_hi) || !(|sum_hi));
	assign sum_sat = sum_ovf ? (sum[SUM_W-1] ? S32_MIN : S32_MAX) : sum[31:0];

	// Difference of the two integral chains.
	assign diff = 33'(up_q) - 33'(acc_q);
	assign diff_ovf = diff[32] != diff[31];
	assign diff_sat = diff_ovf ? (diff[32] ? S32_MIN : S32_MAX) : diff[31:0];

	// Slope numerator and quotient saturation.
	assign dy = 33'(acc_q) - 33'(pa_q);
	assign q_hi = div_quot[DVW-1:31];
	assign q_ovf = !((&q_hi) || !(|q_hi));
	assign q_sat = q_ovf ? (div_quot[DVW-1] ? S32_MIN : S32_MAX) : div_quot[31:0];

	// Divider requests: coefficient over its index plus one, or the slope quotient.
	always_comb begin
		div_ctl.start = 1'b0;
		div_ctl.short_mode = 1'b0;
		div_dividend = DVW'(coef_q[j_q]);
		div_divisor = 32'(j_q) + 32'd1;
		if (state_q == S_TERM && op_q == OP_INTEG) begin
			div_ctl.start = 1'b1;
			div_ctl.short_mode = 1'b1;
		end else if (state_q == S_DONE && op_q == OP_SLOPE && chain_q) begin
			div_ctl.start = 1'b1;
			div_dividend = DVW'(dy) <<< FRAC_BITS;
			div_divisor = 32'(33'(b_q) - 33'(a_q));
		end
	end

	pedi_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(div_ctl),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.sts(div_sts),
		.quotient(div_quot)
	);

	// Coefficient table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= MAX_DEGREE; i++) begin
				coef_q[i] <= '0;
			end
		end else if (state_q == S_IDLE && req.valid && req.operation == OP_LOAD
				&& int'(req.coef_index) <= MAX_DEGREE) begin
			coef_q[req.coef_index[IDX_W-1:0]] <= req.coef_value;
		end
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_LOAD;
			j_q <= '0;
			d_q <= '0;
			first_q <= 1'b0;
			fin_q <= 1'b0;
			chain_q <= 1'b0;
			sat_q <= 1'b0;
			err_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q <= req.operation;
						d_q <= d_used;
						sat_q <= 1'b0;
						err_q <= ST_OK;
						chain_q <= 1'b0;
						fin_q <= 1'b0;
						case (req.operation)
							OP_LOAD: begin
								if (int'(req.coef_index) > MAX_DEGREE) begin
									err_q <= ST_INDEX;
								end
								state_q <= S_OUT;
							end
							OP_EVAL, OP_DERIV, OP_INTEG: begin
								state_q <= S_START;
							end
							OP_SLOPE: begin
								if (req.x_b <= req.x_a) begin
									err_q <= ST_INTERVAL;
									state_q <= S_OUT;
								end else begin
									state_q <= S_START;
								end
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_START: begin
					j_q <= d_q;
					first_q <= 1'b1;
					state_q <= S_TERM;
				end
				S_TERM: begin
					case (op_q)
						OP_DERIV: state_q <= S_TWAIT;
						OP_INTEG: state_q <= S_TDIV;
						default: state_q <= S_ACC;
					endcase
				end
				S_TWAIT: begin
					state_q <= S_ACC;
				end
				S_TDIV: begin
					if (div_sts.done) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					first_q <= 1'b0;
					if (sum_ovf) begin
						sat_q <= 1'b1;
					end
					if (fin_q) begin
						fin_q <= 1'b0;
						state_q <= S_DONE;
					end else if (j_q > jmin) begin
						j_q <= j_q - 1'b1;
						state_q <= S_MUL;
					end else if (op_q == OP_INTEG) begin
						fin_q <= 1'b1;
						state_q <= S_MUL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_MUL: begin
					state_q <= S_MSH;
				end
				S_MSH: begin
					state_q <= fin_q ? S_ACC : S_TERM;
				end
				S_DONE: begin
					if ((op_q == OP_INTEG || op_q == OP_SLOPE) && !chain_q) begin
						chain_q <= 1'b1;
						state_q <= S_START;
					end else if (op_q == OP_SLOPE) begin
						state_q <= S_SDIV;
					end else begin
						if (op_q == OP_INTEG && diff_ovf) begin
							sat_q <= 1'b1;
						end
						state_q <= S_OUT;
					end
				end
				S_SDIV: begin
					if (div_sts.done) begin
						if (q_ovf) begin
							sat_q <= 1'b1;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				a_q <= req.x_a;
				b_q <= req.x_b;
				x_q <= (req.operation == OP_INTEG) ? req.x_b : req.x_a;
				res_q <= '0;
			end
			S_TERM: begin
				if (op_q != OP_DERIV && op_q != OP_INTEG) begin
					t_q <= TW'(coef_q[j_q]);
				end
			end
			S_TWAIT: begin
				t_q <= prod_q[TW-1:0];
			end
			S_TDIV: begin
				t_q <= div_quot[TW-1:0];
			end
			S_ACC: begin
				acc_q <= sum_sat;
			end
			S_MSH: begin
				msh_q <= prod_q[63:FRAC_BITS];
				if (fin_q) begin
					t_q <= '0;
				end
			end
			S_DONE: begin
				if (!chain_q) begin
					up_q <= acc_q;
					pa_q <= acc_q;
					x_q <= (op_q == OP_INTEG) ? a_q : b_q;
				end else if (op_q == OP_INTEG) begin
					res_q <= diff_sat;
				end
				if (op_q == OP_EVAL || op_q == OP_DERIV) begin
					res_q <= acc_q;
				end
			end
			S_SDIV: begin
				res_q <= q_sat;
			end
			default: begin
			end
		endcase
	end

	// Channel handshakes.
	assign req.ready = state_q == S_IDLE;
	assign rsp.valid = state_q == S_OUT;
	assign rsp.result_value = res_q;
	assign rsp.status = (err_q != ST_OK) ? err_q : (sat_q ? ST_SAT : ST_OK);

	// Assertions.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready) else $error("request taken while a result waits");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> !div_sts.busy) else $error("divider started while busy");
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TERM |-> j_q <= d_q) else $error("term index above degree");
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (err_q == ST_INTERVAL || err_q == ST_INDEX) |-> res_q == '0)
		else $error("error item with nonzero value");

endmodule

FILE: sv/pedi_div.sv
// Restoring signed divider, one quotient bit per cycle.
// Depends on pedi_pkg for the control and status structs.
module pedi_div #(
	parameter int FRAC_BITS = pedi_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input pedi_pkg::div_ctl_t ctl,
	input logic signed [32+FRAC_BITS:0] dividend,
	input logic [31:0] divisor,
	output pedi_pkg::div_sts_t sts,
	output logic signed [32+FRAC_BITS:0] quotient
);
	import pedi_pkg::*;

	localparam int DW = 32 + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);

	logic busy_q, done_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] div_q;
	logic [DW:0] mag;
	logic [32:0] shifted;
	logic fits;

	// Magnitude of the dividend; the divisor is always positive.
	assign mag = dividend[DW] ? (DW+1)'(-dividend) : dividend;
	assign shifted = {rem_q, quo_q[DW-1]};
	assign fits = shifted >= {1'b0, div_q};

	// One trial subtraction per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= ctl.short_mode ? CW'(32) : CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			neg_q <= dividend[DW];
			rem_q <= '0;
			div_q <= divisor;
			if (ctl.short_mode) begin
				quo_q <= {mag[31:0], (DW-32)'(0)};
			end else begin
				quo_q <= mag[DW-1:0];
			end
		end else if (busy_q) begin
			rem_q <= fits ? 32'(shifted - {1'b0, div_q}) : shifted[31:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	// Assertions.
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy_q) else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without work");
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider busy and done together");

endmodule

FILE: sim/tb_polynomial_eval_derivative_integral.sv
// Self-checking testbench for the polynomial evaluator: loads, evaluate, derivative,
// integral and secant slope, checked against a Horner predictor kept in the bench.
// Depends on pedi_pkg, pedi_if and the polynomial_eval_derivative_integral RTL.
`timescale 1ns / 1ps

module tb_polynomial_eval_derivative_integral;
	import pedi_pkg::*;

	localparam int MAXD = MAX_DEGREE_DEF;
	localparam int FRACB = FRAC_BITS_DEF;
	localparam int STALL_LIMIT = 20000;
	localparam int LONG_HOLD = 3000;

	typedef struct {
		logic [2:0] op;
		logic [3:0] idx;
		logic signed [31:0] cv;
		logic signed [31:0] xa;
		logic signed [31:0] xb;
	} poly_item_t;

	typedef struct {
		logic signed [31:0] value;
		logic [1:0] status;
	} poly_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [3:0] cfg_wdata = 4'd0;

	pedi_req_if req();
	pedi_rsp_if rsp();

	polynomial_eval_derivative_integral u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// Bench state: pending items, results still owed, and a copy of the block's state.
	poly_item_t pending_items[$];
	poly_result_t owed_results[$];
	longint coef_copy[0:MAXD];
	int degree_copy = 0;
	bit sat_hit;
	int send_idle = 0;
	int recv_idle = 0;
	bit long_hold_go = 1'b0;
	bit long_hold_done = 1'b0;
	int hold_left = 0;
	int error_count = 0;
	int results_seen = 0;
	int idle_cycles = 0;

	always #2 clk = ~clk;

	// Initial values for the request channel and the result ready.
	initial begin
		req.valid = 1'b0;
		req.operation = OP_LOAD;
		req.coef_index = 4'd0;
		req.coef_value = 32'sd0;
		req.x_a = 32'sd0;
		req.x_b = 32'sd0;
		rsp.ready = 1'b0;
		for (int i = 0; i <= MAXD; i++) coef_copy[i] = 0;
	end

	// Saturate to 32 bits and note that it happened.
	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) begin
			sat_hit = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat_hit = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Fixed-point product, floored.
	function automatic longint mul_q(longint a, longint x);
		return (a * x) >>> FRACB;
	endfunction

	function automatic longint poly_at(longint x, int d);
		longint acc;
		acc = coef_copy[d];
		for (int i = d; i > 0; i--) acc = clip32(mul_q(acc, x) + coef_copy[i - 1]);
		return acc;
	endfunction

	function automatic longint slope_of_poly(longint x, int d);
		longint acc;
		if (d == 0) return 0;
		acc = clip32(coef_copy[d] * longint'(d));
		for (int i = d - 1; i > 0; i--)
			acc = clip32(mul_q(acc, x) + coef_copy[i] * longint'(i));
		return acc;
	endfunction

	function automatic longint area_to(longint x, int d);
		longint acc;
		acc = coef_copy[d] / longint'(d + 1);
		for (int i = d; i > 0; i--)
			acc = clip32(mul_q(acc, x) + coef_copy[i - 1] / longint'(i));
		return clip32(mul_q(acc, x));
	endfunction

	// Work out the result of one accepted item and update the table copy.
	function automatic poly_result_t horner_predict(poly_item_t it);
		poly_result_t r;
		longint a, b, v, pa, pb;
		int d;
		a = it.xa;
		b = it.xb;
		d = (degree_copy > MAXD) ? MAXD : degree_copy;
		v = 0;
		r.status = ST_OK;
		sat_hit = 1'b0;
		case (it.op)
			OP_LOAD: begin
				if (it.idx > MAXD) r.status = ST_INDEX;
				else coef_copy[it.idx] = it.cv;
			end
			OP_EVAL: v = poly_at(a, d);
			OP_DERIV: v = slope_of_poly(a, d);
			OP_INTEG: begin
				pb = area_to(b, d);
				pa = area_to(a, d);
				v = clip32(pb - pa);
			end
			OP_SLOPE: begin
				if (b <= a) r.status = ST_INTERVAL;
				else begin
					pa = poly_at(a, d);
					pb = poly_at(b, d);
					v = clip32(((pb - pa) * (64'sd1 <<< FRACB)) / (b - a));
				end
			end
			default: v = 0;
		endcase
		if (r.status == ST_OK && sat_hit) r.status = ST_SAT;
		r.value = v[31:0];
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		error_count++;
		$display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
			results_seen);
	endtask

	// Driver: offers the next pending item, predicting each item as it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				poly_item_t cur;
				cur.op = req.operation;
				cur.idx = req.coef_index;
				cur.cv = req.coef_value;
				cur.xa = req.x_a;
				cur.xb = req.x_b;
				owed_results.push_back(horner_predict(cur));
			end
			if (!req.valid || req.ready) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
					poly_item_t nxt;
					nxt = pending_items.pop_front();
					req.operation <= nxt.op;
					req.coef_index <= nxt.idx;
					req.coef_value <= nxt.cv;
					req.x_a <= nxt.xa;
					req.x_b <= nxt.xb;
					req.valid <= 1'b1;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random ready, a long hold-off once, and the check of each result item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				poly_result_t want;
				results_seen++;
				if (owed_results.size() == 0) begin
					report("unexpected result", rsp.result_value, 0);
				end else begin
					want = owed_results.pop_front();
					if (rsp.result_value !== want.value)
						report("result_value", rsp.result_value, want.value);
					if (rsp.status !== want.status)
						report("status", rsp.status, want.status);
				end
			end
			if (long_hold_go && !long_hold_done && hold_left == 0) begin
				hold_left <= LONG_HOLD;
				long_hold_done <= 1'b1;
				rsp.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp.ready <= (hold_left == 1);
			end else begin
				rsp.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Watchdog: too long with nothing accepted on either side ends the run.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("tb_polynomial_eval_derivative_integral: done, errors");
			$finish;
		end
	end

	// Random Q16.16 value: mostly a few units around zero, sometimes any 32 bits.
	function automatic logic signed [31:0] rand_q();
		case ($urandom_range(9))
			0, 1: return $urandom;
			2: return $signed($urandom_range(131072)) - 65536;
			default: return $signed($urandom_range(393216)) - 196608;
		endcase
	endfunction

	function automatic poly_item_t make_item(logic [2:0] op, logic [3:0] idx,
			logic signed [31:0] cv, logic signed [31:0] xa, logic signed [31:0] xb);
		poly_item_t it;
		it.op = op;
		it.idx = idx;
		it.cv = cv;
		it.xa = xa;
		it.xb = xb;
		return it;
	endfunction

	// A random item; loads fill the table, slopes usually get an increasing interval.
	function automatic poly_item_t rand_item(int d);
		logic signed [31:0] a, b, t;
		int pick;
		pick = $urandom_range(99);
		a = rand_q();
		b = rand_q();
		if (pick < 30) begin
			if ($urandom_range(19) == 0) return make_item(OP_LOAD, 4'($urandom_range(15)),
				$urandom, a, b);
			return make_item(OP_LOAD, 4'($urandom_range((d > MAXD) ? MAXD : d)), rand_q(), a, b);
		end
		if (pick < 45) return make_item(OP_EVAL, 4'($urandom), $urandom, a, b);
		if (pick < 60) return make_item(OP_DERIV, 4'($urandom), $urandom, a, b);
		if (pick < 75) return make_item(OP_INTEG, 4'($urandom), $urandom, a, b);
		if (pick < 96) begin
			if (a > b && $urandom_range(4) != 0) begin
				t = a;
				a = b;
				b = t;
			end
			return make_item(OP_SLOPE, 4'($urandom), $urandom, a, b);
		end
		return make_item(3'($urandom_range(7, 5)), 4'($urandom), $urandom, a, b);
	endfunction

	task automatic write_degree(int d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= 4'(d);
		@(posedge clk);
		cfg_we <= 1'b0;
		degree_copy = d;
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || req.valid || owed_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Stimulus: directed corners, then random phases over degree and idling mixes.
	initial begin
		int degs[6];
		degs = '{10, 15, 3, 0, 7, 1};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Degree 0 after reset: constant polynomial, derivative of a constant.
		pending_items.push_back(make_item(OP_EVAL, 0, 0, 32'sh7FFF_FFFF, 0));
		pending_items.push_back(make_item(OP_LOAD, 0, 32'sh8000_0000, 0, 0));
		pending_items.push_back(make_item(OP_DERIV, 0, 0, 32'sh0001_0000, 0));
		pending_items.push_back(make_item(OP_EVAL, 0, 0, 32'sh8000_0000, 0));
		pending_items.push_back(make_item(OP_INTEG, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF));
		wait_drained();
		write_degree(10);
		// Full table with extremes, then every operation at the edges.
		for (int i = 0; i <= MAXD; i++)
			pending_items.push_back(make_item(OP_LOAD, 4'(i),
				(i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000, 0, 0));
		pending_items.push_back(make_item(OP_LOAD, 4'd15, 32'sh1234_5678, 0, 0));
		pending_items.push_back(make_item(OP_LOAD, 4'd11, 32'sd1, 0, 0));
		pending_items.push_back(make_item(OP_EVAL, 0, 0, 32'sh7FFF_FFFF, 0));
		pending_items.push_back(make_item(OP_DERIV, 0, 0, 32'sh8000_0000, 0));
		pending_items.push_back(make_item(OP_INTEG, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF));
		pending_items.push_back(make_item(OP_SLOPE, 0, 0, 32'sh0001_0000, 32'sh0001_0000));
		pending_items.push_back(make_item(OP_SLOPE, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000));
		pending_items.push_back(make_item(OP_SLOPE, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF));
		pending_items.push_back(make_item(3'd7, 4'd15, 32'shFFFF_FFFF, 32'shFFFF_FFFF,
			32'shFFFF_FFFF));
		pending_items.push_back(make_item(3'd5, 0, 0, 0, 0));
		wait_drained();

		// Random phases; the idling mix changes every two phases.
		for (int ph = 0; ph < 6; ph++) begin
			send_idle = (ph < 2) ? 36 : (ph < 4) ? 66 : 0;
			recv_idle = (ph < 2) ? 66 : (ph < 4) ? 36 : 0;
			write_degree((ph == 5) ? $urandom_range(15) : degs[ph]);
			for (int n = 0; n < 310; n++) pending_items.push_back(rand_item(degree_copy));
			if (ph == 4) begin
				repeat (50) @(posedge clk);
				long_hold_go = 1'b1;
			end
			wait_drained();
		end

		repeat (900) @(posedge clk);
		$display("Covered %0d result items over degrees 0, 3, 7, 10, 15 and one random one,",
			results_seen);
		$display("with both sides idling, a long result hold-off and no-idle stretches.");
		if (error_count == 0) begin
			$display("tb_polynomial_eval_derivative_integral: done, clean");
		end else begin
			$display("tb_polynomial_eval_derivative_integral: done, errors");
		end
		$finish;
	end

endmodule

FILE: polynomial_eval_derivative_integral.f
sv/pedi_pkg.sv
sv/pedi_if.sv
sv/pedi_div.sv
sv/polynomial_eval_derivative_integral.sv
sim/tb_polynomial_eval_derivative_integral.sv
